// ===== rtl/core/aff_xf_pkg.sv =====
// types and constants for the affine point, vector and bounds transform unit
// no dependencies; imported by affine_point_vector_bounds_transform_top
package aff_xf_pkg;

	// transaction kind carried on the slave-side tuser
	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_POINT  = 2'd1,
		MODE_VECTOR = 2'd2,
		MODE_BOUNDS = 2'd3
	} mode_t;

	localparam int WORD_W     = 32;
	localparam int ELEM_CNT   = 12;
	localparam int IDX_W      = 4;
	localparam int IN_DATA_W  = 232;
	localparam int OUT_DATA_W = 192;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t MAX32 = 32'sh7fff_ffff;
	localparam word_t MIN32 = 32'sh8000_0000;

endpackage

// ===== rtl/core/affine_point_vector_bounds_transform_top.sv =====
// affine transform unit: 3x4 fixed-point matrix applied to points, vectors and boxes
// depends on aff_xf_pkg for the mode type, field widths and saturation limits
//
// pipeline: stage 1 captures the input; results leave on m_axis from the stage 4 register
// throughput: one transaction per cycle unless m_axis_tready stalls; eighteen parallel
// multipliers (box min, max corners), per-term min/max, saturating row sums, one stage each
// reset: matrix returns to identity, all pipeline stages empty
module affine_point_vector_bounds_transform_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// elem_index, elem_value, in_x0, in_y0, in_z0, in_x1, in_y1, in_z1, zero pad
	input  logic [aff_xf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic [1:0]                    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_x0, out_y0, out_z0, out_x1, out_y1, out_z1
	output logic [aff_xf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// overflow
	output logic [0:0]                    m_axis_tuser
);
	import aff_xf_pkg::*;

	localparam int PW = 64 - FRAC_BITS;
	localparam int SW = PW + 2;
	localparam word_t ONE = word_t'(64'sd1 <<< FRAC_BITS);

	// input field unpacking
	mode_t            mode_in;
	logic [IDX_W-1:0] elem_index_in;
	word_t            elem_value_in;
	word_t            lo_in [3];
	word_t            hi_in [3];
	logic             in_acc;

	assign mode_in       = mode_t'(s_axis_tuser);
	assign elem_index_in = s_axis_tdata[3:0];
	assign elem_value_in = s_axis_tdata[35:4];
	assign lo_in[0]      = s_axis_tdata[67:36];
	assign lo_in[1]      = s_axis_tdata[99:68];
	assign lo_in[2]      = s_axis_tdata[131:100];
	assign hi_in[0]      = s_axis_tdata[163:132];
	assign hi_in[1]      = s_axis_tdata[195:164];
	assign hi_in[2]      = s_axis_tdata[227:196];
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// stage handshake chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic free1, free2, free3, free4;

	assign free4 = !v_s4 || m_axis_tready;
	assign free3 = !v_s3 || free4;
	assign free2 = !v_s2 || free3;
	assign free1 = !v_s1 || free2;
	assign s_axis_tready = free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (free1) v_s1 <= in_acc && (mode_in != MODE_LOAD);
			if (free2) v_s2 <= v_s1;
			if (free3) v_s3 <= v_s2;
			if (free4) v_s4 <= v_s3;
		end
	end

	// matrix store, identity after reset, written by load transactions
	word_t mat_q [ELEM_CNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ELEM_CNT; i++) begin
				mat_q[i] <= (i == 0 || i == 5 || i == 10) ? ONE : '0;
			end
		end else if (in_acc && mode_in == MODE_LOAD && elem_index_in < IDX_W'(ELEM_CNT)) begin
			mat_q[elem_index_in] <= elem_value_in;
		end
	end

	// stage 1: operand capture; point and vector use the same corner twice
	word_t lo_s1 [3];
	word_t hi_s1 [3];
	logic  with_t_s1, bounds_s1;

	always_ff @(posedge clk) begin
		if (free1) begin
			for (int i = 0; i < 3; i++) begin
				lo_s1[i] <= lo_in[i];
				hi_s1[i] <= (mode_in == MODE_BOUNDS) ? hi_in[i] : lo_in[i];
			end
			with_t_s1 <= (mode_in != MODE_VECTOR);
			bounds_s1 <= (mode_in == MODE_BOUNDS);
		end
	end

	// products of both corners, floored to the fraction position
	logic signed [63:0]   full_lo [9];
	logic signed [63:0]   full_hi [9];
	logic signed [PW-1:0] plo_d [9];
	logic signed [PW-1:0] phi_d [9];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				full_lo[r*3+c] = 64'(mat_q[r*4+c]) * 64'(lo_s1[c]);
				full_hi[r*3+c] = 64'(mat_q[r*4+c]) * 64'(hi_s1[c]);
				plo_d[r*3+c]   = PW'(full_lo[r*3+c] >>> FRAC_BITS);
				phi_d[r*3+c]   = PW'(full_hi[r*3+c] >>> FRAC_BITS);
			end
		end
	end

	// stage 2: registered products and translation column
	logic signed [PW-1:0] plo_s2 [9];
	logic signed [PW-1:0] phi_s2 [9];
	word_t                t_s2 [3];
	logic                 bounds_s2;

	always_ff @(posedge clk) begin
		if (free2) begin
			for (int i = 0; i < 9; i++) begin
				plo_s2[i] <= plo_d[i];
				phi_s2[i] <= phi_d[i];
			end
			for (int r = 0; r < 3; r++) begin
				t_s2[r] <= with_t_s1 ? mat_q[r*4+3] : '0;
			end
			bounds_s2 <= bounds_s1;
		end
	end

	// stage 3: per-term min and max; the row sum separates over the columns
	logic signed [PW-1:0] mn_s3 [9];
	logic signed [PW-1:0] mx_s3 [9];
	word_t                t_s3 [3];
	logic                 bounds_s3;

	always_ff @(posedge clk) begin
		if (free3) begin
			for (int i = 0; i < 9; i++) begin
				mn_s3[i] <= (plo_s2[i] < phi_s2[i]) ? plo_s2[i] : phi_s2[i];
				mx_s3[i] <= (plo_s2[i] < phi_s2[i]) ? phi_s2[i] : plo_s2[i];
			end
			t_s3      <= t_s2;
			bounds_s3 <= bounds_s2;
		end
	end

	// row sums and saturation
	logic signed [SW-1:0] smin [3];
	logic signed [SW-1:0] smax [3];
	word_t                rmin_d [3];
	word_t                rmax_d [3];
	logic                 ovf_d;

	always_comb begin
		ovf_d = 1'b0;
		for (int r = 0; r < 3; r++) begin
			smin[r] = SW'(mn_s3[r*3]) + SW'(mn_s3[r*3+1]) + SW'(mn_s3[r*3+2]) + SW'(t_s3[r]);
			smax[r] = SW'(mx_s3[r*3]) + SW'(mx_s3[r*3+1]) + SW'(mx_s3[r*3+2]) + SW'(t_s3[r]);
			if (smin[r] > SW'(MAX32)) begin
				rmin_d[r] = MAX32;
			end else if (smin[r] < SW'(MIN32)) begin
				rmin_d[r] = MIN32;
				ovf_d     = 1'b1;
			end else begin
				rmin_d[r] = word_t'(smin[r]);
			end
			if (smax[r] > SW'(MAX32)) begin
				rmax_d[r] = MAX32;
				ovf_d     = 1'b1;
			end else if (smax[r] < SW'(MIN32)) begin
				rmax_d[r] = MIN32;
			end else begin
				rmax_d[r] = word_t'(smax[r]);
			end
		end
	end

	// stage 4: result register
	word_t rmin_s4 [3];
	word_t rmax_s4 [3];
	logic  ovf_s4, bounds_s4;

	always_ff @(posedge clk) begin
		if (free4) begin
			for (int r = 0; r < 3; r++) begin
				rmin_s4[r] <= rmin_d[r];
				rmax_s4[r] <= bounds_s3 ? rmax_d[r] : '0;
			end
			ovf_s4    <= ovf_d;
			bounds_s4 <= bounds_s3;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {rmax_s4[2], rmax_s4[1], rmax_s4[0],
		rmin_s4[2], rmin_s4[1], rmin_s4[0]};
	assign m_axis_tuser  = ovf_s4;

	// a load with a valid index lands in the matrix on the next edge
	a_load_write: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && mode_in == MODE_LOAD && elem_index_in < IDX_W'(ELEM_CNT))
		|=> mat_q[$past(elem_index_in)] == $past(elem_value_in))
		else $error("matrix element not written by load");

	// stage 3 fills only from stage 2, the stage before it
	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s3) |-> $past(v_s2))
		else $error("stage 3 filled without stage 2");

	// box results keep min not above max
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && bounds_s4) |-> (rmin_s4[0] <= rmax_s4[0] && rmin_s4[1] <= rmax_s4[1]
		&& rmin_s4[2] <= rmax_s4[2]))
		else $error("box minimum above maximum");

	// point and vector results leave the upper corner at zero
	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !bounds_s4) |-> (rmax_s4[0] == '0 && rmax_s4[1] == '0 && rmax_s4[2] == '0))
		else $error("upper corner not zero outside bounds transaction");

	// overflow always shows as a saturated component
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && ovf_s4) |-> (rmin_s4[0] == MIN32 || rmin_s4[1] == MIN32
		|| rmin_s4[2] == MIN32 || rmin_s4[0] == MAX32 || rmin_s4[1] == MAX32
		|| rmin_s4[2] == MAX32 || rmax_s4[0] == MAX32 || rmax_s4[1] == MAX32
		|| rmax_s4[2] == MAX32))
		else $error("overflow without saturated result");

endmodule

// ===== sim/tb.sv =====
// testbench for affine_point_vector_bounds_transform_top: streams matrix loads, points,
// vectors and boxes, predicts every result in fixed point and checks it field by field
// depends on aff_xf_pkg and the rtl top level
module tb;
	import aff_xf_pkg::*;

	localparam int FRAC_BITS    = 16;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_PCT     = 31;
	localparam int HOLD_CYCLES  = 400;

	// one slave-side transaction before packing
	typedef struct {
		mode_t      mode;
		logic [3:0] idx;
		word_t      val;
		word_t      x0, y0, z0, x1, y1, z1;
	} xf_item_t;

	// one master-side transaction
	typedef struct packed {
		word_t x0, y0, z0, x1, y1, z1;
		logic  ovf;
	} xf_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]            s_axis_tuser = MODE_LOAD;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0]            m_axis_tuser;

	xf_item_t   item_feed[$];
	xf_result_t predicted_outputs[$];
	xf_item_t   cur_item;
	word_t      mat_coef[ELEM_CNT];
	int         sent_cnt = 0;
	int         got_cnt = 0;
	int         err_cnt = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;
	int         cycle_cnt = 0;

	affine_point_vector_bounds_transform_top #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// one matrix row applied to (px,py,pz,w): floored products, exact sum, saturation
	function automatic word_t row_sum(input int row, input word_t px, input word_t py,
			input word_t pz, input bit with_t, inout bit ovf);
		longint acc;
		acc = (longint'(mat_coef[row*4]) * longint'(px)) >>> FRAC_BITS;
		acc += (longint'(mat_coef[row*4+1]) * longint'(py)) >>> FRAC_BITS;
		acc += (longint'(mat_coef[row*4+2]) * longint'(pz)) >>> FRAC_BITS;
		if (with_t)
			acc += longint'(mat_coef[row*4+3]);
		if (acc > longint'(MAX32)) begin
			ovf = 1'b1;
			return MAX32;
		end
		if (acc < longint'(MIN32)) begin
			ovf = 1'b1;
			return MIN32;
		end
		return word_t'(acc);
	endfunction

	// apply one accepted transaction to the matrix copy, queue its result if it has one
	function automatic void transform_item(input xf_item_t it);
		xf_result_t res;
		word_t      px, py, pz;
		word_t      r[3];
		bit         ovf;
		ovf = 1'b0;
		res = '0;
		case (it.mode)
			MODE_LOAD: begin
				if (it.idx < ELEM_CNT)
					mat_coef[it.idx] = it.val;
				return;
			end
			MODE_POINT, MODE_VECTOR: begin
				res.x0 = row_sum(0, it.x0, it.y0, it.z0, it.mode == MODE_POINT, ovf);
				res.y0 = row_sum(1, it.x0, it.y0, it.z0, it.mode == MODE_POINT, ovf);
				res.z0 = row_sum(2, it.x0, it.y0, it.z0, it.mode == MODE_POINT, ovf);
			end
			default: begin
				// all eight corners, min and max taken over saturated values
				for (int c = 0; c < 8; c++) begin
					px = c[2] ? it.x1 : it.x0;
					py = c[1] ? it.y1 : it.y0;
					pz = c[0] ? it.z1 : it.z0;
					for (int row = 0; row < 3; row++)
						r[row] = row_sum(row, px, py, pz, 1'b1, ovf);
					if (c == 0 || r[0] < res.x0) res.x0 = r[0];
					if (c == 0 || r[1] < res.y0) res.y0 = r[1];
					if (c == 0 || r[2] < res.z0) res.z0 = r[2];
					if (c == 0 || r[0] > res.x1) res.x1 = r[0];
					if (c == 0 || r[1] > res.y1) res.y1 = r[1];
					if (c == 0 || r[2] > res.z1) res.z1 = r[2];
				end
			end
		endcase
		res.ovf = ovf;
		predicted_outputs.push_back(res);
	endfunction

	function automatic xf_item_t make_item(input mode_t mode, input logic [3:0] idx,
			input word_t val, input word_t x0, input word_t y0, input word_t z0,
			input word_t x1, input word_t y1, input word_t z1);
		xf_item_t it;
		it.mode = mode;
		it.idx  = idx;
		it.val  = val;
		it.x0 = x0; it.y0 = y0; it.z0 = z0;
		it.x1 = x1; it.y1 = y1; it.z1 = z1;
		return it;
	endfunction

	// mostly moderate values, some full-range words and some corner values
	function automatic word_t rand_word(input int spread);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			case ($urandom_range(5))
				0: return MAX32;
				1: return MIN32;
				2: return 32'sd0;
				3: return 32'sd65536;
				4: return -32'sd65536;
				default: return -32'sd1;
			endcase
		end
		if (pick < 35)
			return word_t'($urandom);
		return word_t'(int'($urandom_range(2 * spread)) - spread);
	endfunction

	function automatic void push_random(input mode_t mode, input logic [3:0] idx);
		item_feed.push_back(make_item(mode, idx, rand_word(1 << 18),
			rand_word(1 << 24), rand_word(1 << 24), rand_word(1 << 24),
			rand_word(1 << 24), rand_word(1 << 24), rand_word(1 << 24)));
	endfunction

	function automatic void check_field(input string tag, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %h, actual %h", $time, tag, want, got);
			err_cnt++;
		end
	endfunction

	// driver: offers the next queued item once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= MODE_LOAD;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				transform_item(cur_item);
				sent_cnt++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (item_feed.size() != 0 && ((sent_cnt >= 700 && sent_cnt < 900) ||
						$urandom_range(99) >= IDLE_PCT)) begin
					cur_item = item_feed.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {4'b0, cur_item.z1, cur_item.y1, cur_item.x1,
						cur_item.z0, cur_item.y0, cur_item.x0, cur_item.val, cur_item.idx};
					s_axis_tuser  <= cur_item.mode;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transaction, stalls at random and once for a long time
	always @(posedge clk or negedge arst_n) begin
		xf_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_cnt++;
				if (predicted_outputs.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %h %h", $time,
						m_axis_tdata, m_axis_tuser);
					err_cnt++;
				end else begin
					want = predicted_outputs.pop_front();
					check_field("out_x0", want.x0, m_axis_tdata[31:0]);
					check_field("out_y0", want.y0, m_axis_tdata[63:32]);
					check_field("out_z0", want.z0, m_axis_tdata[95:64]);
					check_field("out_x1", want.x1, m_axis_tdata[127:96]);
					check_field("out_y1", want.y1, m_axis_tdata[159:128]);
					check_field("out_z1", want.z1, m_axis_tdata[191:160]);
					check_field("overflow", {31'b0, want.ovf}, {31'b0, m_axis_tuser});
				end
			end
			if (got_cnt == 300 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (got_cnt >= 450 && got_cnt < 600) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// timeout
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("[affine_point_vector_bounds_transform_top] ERROR");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int          rnd_cnt;
		int unsigned pick;
		logic [3:0]  idx;
		for (int i = 0; i < ELEM_CNT; i++)
			mat_coef[i] = 32'sd0;
		mat_coef[0]  = 32'sd65536;
		mat_coef[5]  = 32'sd65536;
		mat_coef[10] = 32'sd65536;

		// identity matrix: extreme points, vectors, an inverted box
		item_feed.push_back(make_item(MODE_POINT, 4'd0, 32'sd0,
			MAX32, MIN32, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_VECTOR, 4'd15, -32'sd1,
			MIN32, MAX32, -32'sd1, MAX32, MAX32, MAX32));
		item_feed.push_back(make_item(MODE_BOUNDS, 4'd0, 32'sd0,
			32'sd65536, MIN32, -32'sd65536, MIN32, MAX32, 32'sd131072));
		// out-of-range loads are ignored
		item_feed.push_back(make_item(MODE_LOAD, 4'd12, MAX32,
			32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_LOAD, 4'd15, MIN32,
			-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
		item_feed.push_back(make_item(MODE_POINT, 4'd0, 32'sd0,
			32'sd196608, -32'sd65536, 32'sd1, 32'sd0, 32'sd0, 32'sd0));
		// translations at the top and bottom of the range, then saturating sums
		item_feed.push_back(make_item(MODE_LOAD, 4'd3, MAX32,
			32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_LOAD, 4'd7, MIN32,
			32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_POINT, 4'd0, 32'sd0,
			32'sd65536, -32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_VECTOR, 4'd0, 32'sd0,
			32'sd65536, -32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_BOUNDS, 4'd0, 32'sd0,
			-32'sd65536, -32'sd65536, 32'sd0, 32'sd65536, 32'sd65536, 32'sd0));
		// most negative coefficient times most negative coordinate
		item_feed.push_back(make_item(MODE_LOAD, 4'd0, MIN32,
			32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_LOAD, 4'd11, MAX32,
			32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_POINT, 4'd0, 32'sd0,
			MIN32, MIN32, MIN32, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_VECTOR, 4'd0, 32'sd0,
			MIN32, MAX32, MAX32, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_BOUNDS, 4'd0, 32'sd0,
			MIN32, MIN32, MIN32, MAX32, MAX32, MAX32));
		// negative fractional coefficients exercise the floor on truncation
		item_feed.push_back(make_item(MODE_LOAD, 4'd1, -32'sd1,
			32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_LOAD, 4'd6, -32'sd32768,
			32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_POINT, 4'd0, 32'sd0,
			32'sd3, 32'sd1, -32'sd3, 32'sd0, 32'sd0, 32'sd0));
		item_feed.push_back(make_item(MODE_BOUNDS, 4'd0, 32'sd0,
			32'sd5, 32'sd7, -32'sd9, -32'sd5, -32'sd7, 32'sd9));

		#1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender pauses until the block has drained; checked between edges
		while (item_feed.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0)
			@(negedge clk);

		// random part: whole matrix loads with random content, single loads, transforms
		rnd_cnt = 0;
		while (rnd_cnt < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				for (int i = 0; i < ELEM_CNT; i++)
					push_random(MODE_LOAD, 4'(i));
				rnd_cnt += ELEM_CNT;
			end else if (pick < 12) begin
				idx = 4'($urandom_range(15));
				push_random(MODE_LOAD, idx);
				if (idx < ELEM_CNT)
					rnd_cnt++;
			end else begin
				push_random(mode_t'($urandom_range(1, 3)), 4'($urandom_range(15)));
				rnd_cnt++;
			end
		end

		while (item_feed.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && predicted_outputs.size() == 0)
			$display("[affine_point_vector_bounds_transform_top] OK");
		else
			$display("[affine_point_vector_bounds_transform_top] ERROR");
		$finish;
	end

endmodule
